// ===== rtl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared constants for the lru key-value cache: store depth, widths,
// register map and defaults
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int Depth = 16;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  localparam int KeyW = 32;
  localparam int ValW = 32;
  localparam int CapW = 5;

  localparam int AddrW = 3;
  localparam int DataW = 32;

  // register index, taken from paddr above the byte offset
  localparam logic CapRegIdx = 1'b0;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  localparam logic KindGet = 1'b0;
  localparam logic KindPut = 1'b1;

  localparam logic signed [ValW-1:0] MissValue = -32'sd1;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value store with least-recently-used replacement
// ----------------------------------------------------------------------------
// A get or put is taken when start is high and busy is low. One 32-bit key
// comparator walks the entries one per cycle, so every operation first scans
// all Depth entries. A get strobes result_valid_o with hit_o and read_value_o
// once its scan is done, and busy drops in the same cycle. A put gives no
// result; after the scan it goes idle when the key is stored, inserts when
// the store holds fewer entries than the capacity, and otherwise must evict
// first, after which a second walk looks for the freed entry. Results
// cannot be stalled: capture them in the cycle of the strobe. Capacity is
// written over the APB port; write it only while busy is low, the block
// itself does not enforce this. 0 acts as 1, and values above Depth act as Depth.
module lru_key_value_cache (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // operation channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 kind_i,
  input  logic signed [lkvc_pkg::KeyW-1:0]     key_i,
  input  logic signed [lkvc_pkg::ValW-1:0]     value_i,
  // result channel
  output logic                                 result_valid_o,
  output logic                                 hit_o,
  output logic signed [lkvc_pkg::ValW-1:0]     read_value_o,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lkvc_pkg::AddrW-1:0]           paddr,
  input  logic [lkvc_pkg::DataW-1:0]           pwdata,
  output logic [lkvc_pkg::DataW-1:0]           prdata,
  output logic                                 pready
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScan   = 3'd1;
  localparam logic [2:0] StDone   = 3'd2;
  localparam logic [2:0] StEvict  = 3'd3;
  localparam logic [2:0] StFree   = 3'd4;
  localparam logic [2:0] StInsert = 3'd5;

  localparam int IdxW  = lkvc_pkg::IdxW;
  localparam int CntW  = lkvc_pkg::CntW;
  localparam int Depth = lkvc_pkg::Depth;

  logic [2:0] state_q, state_d;

  logic [lkvc_pkg::CapW-1:0] cap_q, cap_d;
  logic [CntW-1:0]           cap_eff;

  logic signed [lkvc_pkg::KeyW-1:0] keys_q [Depth];
  logic signed [lkvc_pkg::ValW-1:0] vals_q [Depth];
  logic [Depth-1:0]                 valid_q, valid_d;
  logic [IdxW-1:0]                  rank_q [Depth];
  logic [IdxW-1:0]                  rank_d [Depth];
  logic [CntW-1:0]                  count_q, count_d;

  logic                             kind_q, kind_d;
  logic signed [lkvc_pkg::KeyW-1:0] key_q, key_d;
  logic signed [lkvc_pkg::ValW-1:0] val_q, val_d;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            hit_found_q, hit_found_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic            free_found_q, free_found_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;

  logic                             res_valid_q, res_valid_d;
  logic                             res_hit_q, res_hit_d;
  logic signed [lkvc_pkg::ValW-1:0] res_val_q, res_val_d;

  logic            key_match;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic            wr_key;
  logic [IdxW-1:0] touch_rank;
  logic            cfg_wr;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cap_d = cap_q;
    if (cfg_wr && paddr[2] == lkvc_pkg::CapRegIdx) begin
      cap_d = pwdata[lkvc_pkg::CapW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lkvc_pkg::CapRegIdx) begin
      prdata = lkvc_pkg::DataW'(cap_q);
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CntW'(1);
    end else if (int'(cap_q) > Depth) begin
      cap_eff = CntW'(Depth);
    end else begin
      cap_eff = CntW'(cap_q);
    end
  end

  // the shared comparator
  assign key_match  = valid_q[idx_q] && (keys_q[idx_q] == key_q);
  assign touch_rank = rank_q[hit_idx_q];

  // ---------------- sequencer ----------------
  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    rank_d       = rank_q;
    count_d      = count_q;
    kind_d       = kind_q;
    key_d        = key_q;
    val_d        = val_q;
    idx_d        = idx_q;
    hit_found_d  = hit_found_q;
    hit_idx_d    = hit_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    res_valid_d  = 1'b0;
    res_hit_d    = res_hit_q;
    res_val_d    = res_val_q;
    wr_en        = 1'b0;
    wr_key       = 1'b0;
    wr_idx       = hit_idx_q;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          kind_d       = kind_i;
          key_d        = key_i;
          val_d        = value_i;
          idx_d        = '0;
          hit_found_d  = 1'b0;
          free_found_d = 1'b0;
          state_d      = StScan;
        end
      end
      StScan: begin
        if (key_match) begin
          hit_found_d = 1'b1;
          hit_idx_d   = idx_q;
        end
        if (!valid_q[idx_q] && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end
        if (idx_q == IdxW'(Depth - 1)) begin
          state_d = StDone;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      StDone: begin
        state_d = StIdle;
        if (hit_found_q) begin
          // make the hit entry most recent
          for (int i = 0; i < Depth; i++) begin
            if (valid_q[i] && rank_q[i] < touch_rank) begin
              rank_d[i] = rank_q[i] + IdxW'(1);
            end
          end
          rank_d[hit_idx_q] = '0;
          if (kind_q == lkvc_pkg::KindPut) begin
            wr_en = 1'b1;
          end else begin
            res_valid_d = 1'b1;
            res_hit_d   = 1'b1;
            res_val_d   = vals_q[hit_idx_q];
          end
        end else if (kind_q == lkvc_pkg::KindGet) begin
          res_valid_d = 1'b1;
          res_hit_d   = 1'b0;
          res_val_d   = lkvc_pkg::MissValue;
        end else if (count_q >= cap_eff) begin
          state_d = StEvict;
        end else begin
          state_d = StInsert;
        end
      end
      StEvict: begin
        // drop every entry ranked at or past capacity-1 in one go
        for (int i = 0; i < Depth; i++) begin
          if (CntW'(rank_q[i]) >= cap_eff - CntW'(1)) begin
            valid_d[i] = 1'b0;
          end
        end
        count_d = cap_eff - CntW'(1);
        idx_d   = '0;
        state_d = StFree;
      end
      StFree: begin
        if (!valid_q[idx_q]) begin
          free_idx_d = idx_q;
          state_d    = StInsert;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      StInsert: begin
        for (int i = 0; i < Depth; i++) begin
          if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + IdxW'(1);
          end
        end
        rank_d[free_idx_q]  = '0;
        valid_d[free_idx_q] = 1'b1;
        count_d             = count_q + CntW'(1);
        wr_en               = 1'b1;
        wr_key              = 1'b1;
        wr_idx              = free_idx_q;
        state_d             = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cap_q       <= lkvc_pkg::CapReset;
      valid_q     <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < Depth; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      rank_q      <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    key_q        <= key_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    hit_found_q  <= hit_found_d;
    hit_idx_q    <= hit_idx_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    res_hit_q    <= res_hit_d;
    res_val_q    <= res_val_d;
    if (wr_en) begin
      vals_q[wr_idx] <= val_q;
      if (wr_key) begin
        keys_q[wr_idx] <= key_q;
      end
    end
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = res_valid_q;
  assign hit_o          = res_hit_q;
  assign read_value_o   = res_val_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= Depth)
    else $error("entry count above depth");

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> ($countones(valid_q) == int'(count_q)))
    else $error("entry count disagrees with valid bits");

  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == StDone && $past(kind_q) == lkvc_pkg::KindGet))
    else $error("result beat not caused by a finished get");

  a_start_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == StScan && idx_q == '0))
    else $error("accepted operation did not begin a scan");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the lru key-value cache: gets and puts go in on
// the command channel, a cache model predicts each lookup result and the
// monitor compares every strobed beat against it; capacity is changed over
// apb between phases, including below the current fill level
// ----------------------------------------------------------------------------
module testbench;

  localparam int DrainCycles = 40;
  localparam int StallLimit  = 2000;

  localparam logic [lkvc_pkg::AddrW-1:0] CapAddr    = {lkvc_pkg::CapRegIdx, 2'b00};
  localparam logic [lkvc_pkg::AddrW-1:0] UnusedAddr = 3'd4;

  typedef struct packed {
    logic                      hit;
    logic [lkvc_pkg::ValW-1:0] value;
  } lookup_t;

  // lru cache model with its own copy of the capacity register
  class cache_model;
    logic [lkvc_pkg::KeyW-1:0] keys [lkvc_pkg::Depth];
    logic [lkvc_pkg::ValW-1:0] vals [lkvc_pkg::Depth];
    bit                        valid [lkvc_pkg::Depth];
    int unsigned               rank [lkvc_pkg::Depth];
    int unsigned               count;
    logic [lkvc_pkg::CapW-1:0] cap_reg;
    lookup_t                   lookups_due [$];
    int                        errors;

    function new();
      foreach (valid[i]) begin
        valid[i] = 1'b0;
        rank[i]  = 0;
      end
      count   = 0;
      cap_reg = lkvc_pkg::CapReset;
      errors  = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [lkvc_pkg::DataW-1:0] data);
      if (idx == int'(lkvc_pkg::CapRegIdx)) cap_reg = data[lkvc_pkg::CapW-1:0];
    endfunction

    function int unsigned cap_limit();
      if (cap_reg == 0) return 1;
      if (cap_reg > lkvc_pkg::Depth) return lkvc_pkg::Depth;
      return cap_reg;
    endfunction

    function int find_entry(logic [lkvc_pkg::KeyW-1:0] k);
      for (int i = 0; i < lkvc_pkg::Depth; i++)
        if (valid[i] && keys[i] == k) return i;
      return -1;
    endfunction

    function void make_recent(int e);
      int unsigned r;
      r = rank[e];
      for (int i = 0; i < lkvc_pkg::Depth; i++)
        if (valid[i] && rank[i] < r) rank[i]++;
      rank[e] = 0;
    endfunction

    function void drop_oldest();
      int victim;
      victim = -1;
      for (int i = 0; i < lkvc_pkg::Depth; i++)
        if (valid[i] && (victim < 0 || rank[i] > rank[victim])) victim = i;
      if (victim < 0) return;
      valid[victim] = 1'b0;
      rank[victim]  = 0;
      if (count > 0) count--;
    endfunction

    function void insert_entry(logic [lkvc_pkg::KeyW-1:0] k, logic [lkvc_pkg::ValW-1:0] v);
      int slot;
      slot = -1;
      while (count > 0 && count >= cap_limit()) drop_oldest();
      for (int i = 0; i < lkvc_pkg::Depth; i++)
        if (!valid[i]) begin
          slot = i;
          break;
        end
      if (slot < 0) return;
      for (int i = 0; i < lkvc_pkg::Depth; i++)
        if (valid[i]) rank[i]++;
      keys[slot]  = k;
      vals[slot]  = v;
      valid[slot] = 1'b1;
      rank[slot]  = 0;
      count++;
    endfunction

    // called for every accepted command beat
    function void note_op(logic kind, logic [lkvc_pkg::KeyW-1:0] k,
                          logic [lkvc_pkg::ValW-1:0] v);
      int      e;
      lookup_t res;
      e = find_entry(k);
      if (kind == lkvc_pkg::KindPut) begin
        if (e >= 0) begin
          vals[e] = v;
          make_recent(e);
        end else begin
          insert_entry(k, v);
        end
      end else begin
        if (e >= 0) begin
          res.hit   = 1'b1;
          res.value = vals[e];
          make_recent(e);
        end else begin
          res.hit   = 1'b0;
          res.value = lkvc_pkg::MissValue;
        end
        lookups_due.push_back(res);
      end
    endfunction

    function void check_lookup(logic hit, logic [lkvc_pkg::ValW-1:0] value);
      lookup_t want;
      if (lookups_due.size() == 0) begin
        $display("%0t: unexpected result beat, hit %0b value %h", $time, hit, value);
        errors++;
        return;
      end
      want = lookups_due.pop_front();
      if (hit !== want.hit) begin
        $display("%0t: hit mismatch, expected %0b actual %0b", $time, want.hit, hit);
        errors++;
      end
      if (value !== want.value) begin
        $display("%0t: read_value mismatch, expected %h actual %h",
                 $time, want.value, value);
        errors++;
      end
    endfunction

    function int pending();
      return lookups_due.size();
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             start;
  logic                             busy;
  logic                             kind_i;
  logic signed [lkvc_pkg::KeyW-1:0] key_i;
  logic signed [lkvc_pkg::ValW-1:0] value_i;
  logic                             result_valid_o;
  logic                             hit_o;
  logic signed [lkvc_pkg::ValW-1:0] read_value_o;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [lkvc_pkg::AddrW-1:0]       paddr;
  logic [lkvc_pkg::DataW-1:0]       pwdata;
  logic [lkvc_pkg::DataW-1:0]       prdata;
  logic                             pready;

  cache_model model = new();

  logic [lkvc_pkg::KeyW-1:0] key_pool [24];
  bit                        no_gaps;
  int                        stall_cycles;

  lru_key_value_cache dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .result_valid_o(result_valid_o),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result beats cannot be held off, so every strobe is checked here
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) model.check_lookup(hit_o, read_value_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic issue(logic kind, logic [lkvc_pkg::KeyW-1:0] k,
                       logic [lkvc_pkg::ValW-1:0] v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start   <= 1'b1;
    kind_i  <= kind;
    key_i   <= k;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    model.note_op(kind, k, v);
    @(negedge clk_i);
  endtask

  // a put may still be running after the last lookup came back
  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk_i);
    while (model.pending() > 0 || busy) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [lkvc_pkg::AddrW-1:0] addr,
                           logic [lkvc_pkg::DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    model.write_reg(32'(addr >> 2), data);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_read_check(logic [lkvc_pkg::AddrW-1:0] addr,
                                logic [lkvc_pkg::CapW-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[lkvc_pkg::CapW-1:0] !== want) begin
      $display("%0t: capacity readback mismatch, expected %0d actual %0d",
               $time, want, prdata[lkvc_pkg::CapW-1:0]);
      model.errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper pwdata bits are junk on purpose, only the low bits are kept
  task automatic set_capacity(logic [lkvc_pkg::CapW-1:0] cap);
    wait_idle();
    reg_write(CapAddr, {(lkvc_pkg::DataW - lkvc_pkg::CapW)'($urandom()), cap});
    reg_read_check(CapAddr, cap);
  endtask

  function automatic logic [31:0] draw_word();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_directed();
    no_gaps = 1'b0;
    issue(lkvc_pkg::KindGet, 32'h0000_0000, 32'h0000_0000);   // empty store
    issue(lkvc_pkg::KindPut, 32'h8000_0000, 32'h7fff_ffff);
    issue(lkvc_pkg::KindPut, 32'h7fff_ffff, 32'h8000_0000);
    issue(lkvc_pkg::KindPut, 32'h0000_0000, 32'h0000_0000);
    issue(lkvc_pkg::KindPut, 32'hffff_ffff, 32'hffff_ffff);
    issue(lkvc_pkg::KindGet, 32'hffff_ffff, 32'h1234_5678);   // hit that reads like a miss
    issue(lkvc_pkg::KindGet, 32'h8000_0000, 32'hffff_ffff);
    issue(lkvc_pkg::KindGet, 32'h7fff_ffff, 32'h0000_0000);
    issue(lkvc_pkg::KindPut, 32'h0000_0000, 32'h5a5a_a5a5);   // overwrite
    issue(lkvc_pkg::KindGet, 32'h0000_0000, 32'h0000_0000);
    issue(lkvc_pkg::KindGet, 32'h0000_0005, 32'h0000_0000);
    // shrink below the fill level: stored keys stay until a new key comes
    set_capacity(5'd2);
    issue(lkvc_pkg::KindGet, 32'h8000_0000, 32'h0);
    issue(lkvc_pkg::KindPut, 32'h7fff_ffff, 32'h0000_0042);
    issue(lkvc_pkg::KindPut, 32'h0000_002a, 32'h0000_0001);
    issue(lkvc_pkg::KindGet, 32'h8000_0000, 32'h0);
    issue(lkvc_pkg::KindGet, 32'h7fff_ffff, 32'h0);
    issue(lkvc_pkg::KindGet, 32'h0000_002a, 32'h0);
    // zero behaves as one entry
    set_capacity(5'd0);
    issue(lkvc_pkg::KindPut, 32'h0000_002b, 32'h0000_0002);
    issue(lkvc_pkg::KindPut, 32'h0000_002c, 32'h0000_0003);
    issue(lkvc_pkg::KindGet, 32'h0000_002b, 32'h0);
    issue(lkvc_pkg::KindGet, 32'h0000_002c, 32'h0);
    // a write to an unmapped index must not touch the capacity
    wait_idle();
    reg_write(UnusedAddr, 32'h0000_0010);
    reg_read_check(CapAddr, 5'd0);
    issue(lkvc_pkg::KindPut, 32'h0000_002d, 32'h0000_0004);
    issue(lkvc_pkg::KindGet, 32'h0000_002c, 32'h0);
    issue(lkvc_pkg::KindGet, 32'h0000_002d, 32'h0);
  endtask

  task automatic run_phase(logic [lkvc_pkg::CapW-1:0] cap, int items);
    int span;
    set_capacity(cap);
    repeat (4) key_pool[$urandom_range(0, 23)] = draw_word();
    span    = model.cap_limit() + $urandom_range(0, 6);
    if (span > 24) span = 24;
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (items) begin
      logic [lkvc_pkg::KeyW-1:0] k;
      k = ($urandom_range(0, 9) == 0) ? draw_word() : key_pool[$urandom_range(0, span - 1)];
      issue(1'($urandom_range(0, 1)), k, draw_word());
    end
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    kind_i  = lkvc_pkg::KindGet;
    key_i   = '0;
    value_i = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    foreach (key_pool[i]) key_pool[i] = draw_word();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    foreach (key_pool[i]) begin
      run_phase(5'd16, 100);
      if (i == 0) begin
        run_phase(5'd1, 40);
        run_phase(5'd31, 50);
        run_phase(5'd3, 50);
        run_phase(5'd0, 30);
        run_phase(5'd17, 50);
        run_phase(5'd8, 50);
        run_phase(5'd2, 40);
        run_phase(5'd12, 50);
        run_phase(5'($urandom_range(0, 31)), 50);
        run_phase(5'd15, 50);
        break;
      end
    end

    wait_idle();
    if (model.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
